[src/sdt_pkg.sv]
package sdt_pkg;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_FOCUS = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_REJECTED   = 3'd0,
    ST_UPDATED    = 3'd1,
    ST_ADDED      = 3'd2,
    ST_REPLACED   = 3'd3,
    ST_FOCUS_SET  = 3'd4,
    ST_FOCUS_REFD = 3'd5,
    ST_CLEARED    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_WRITE
  } state_t;

  // Control from the table sequencer to the recent-packet ring.
  typedef struct packed {
    logic claim;
    logic clear;
  } ring_ctrl_t;

  // Descriptive part of one table entry; the last-seen time lives apart.
  typedef struct packed {
    logic [47:0]       addr;
    logic [7:0]        kind;
    logic [7:0]        flag;
    logic signed [7:0] rssi;
  } meta_t;

endpackage

[src/sdt_ring.sv]
module sdt_ring
  import sdt_pkg::*;
#(
  parameter int RING_SLOTS = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ring_ctrl_t                      ctrl,
  output logic [$clog2(RING_SLOTS)-1:0]   slot,
  output logic [$clog2(RING_SLOTS+1)-1:0] fill
);

  localparam int RW = $clog2(RING_SLOTS);
  localparam int FW = $clog2(RING_SLOTS + 1);

  logic [RW-1:0] head;
  logic [RW-1:0] tail;
  logic [RW-1:0] head_inc;
  logic [RW-1:0] tail_inc;

  assign head_inc = (head == RW'(RING_SLOTS - 1)) ? '0 : head + RW'(1);
  assign tail_inc = (tail == RW'(RING_SLOTS - 1)) ? '0 : tail + RW'(1);
  assign slot = tail;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (ctrl.claim) begin
      tail <= tail_inc;
      // A full ring drops its oldest slot.
      if (tail_inc == head) begin
        head <= head_inc;
      end
      if (fill < FW'(RING_SLOTS)) begin
        fill <= fill + FW'(1);
      end
    end
  end

endmodule

[src/scan_device_table_oldest_replace_core.sv]
// Seen-device table with oldest-entry replacement and a ring of recent packets.
//
// Command channel: an item is taken at a rising edge with start high and busy
// low. Operations are scan report, set focus and clear. Every item gives one
// result beat: done is high for exactly one cycle with status, entry_index,
// to_recent and recent_slot; device_count, focus_index and recent_count show
// the state after the step and hold until the next item changes it.
// Set focus, clear, unused codes and rejected scan reports answer one cycle
// after acceptance. A scan report walks the entry memory one entry a cycle
// through its single read port and stops at the first hit or, on a miss, at
// entry device_count - 1; on an empty table the walk is skipped and the item
// goes straight to its write-back, where the result is formed. The walk also
// tracks the oldest time, so replacement costs no second pass. busy stays high
// for the whole walk and its write-back and is low again in the cycle of the
// result beat, so the next item can be taken while done is high.
// The receiver cannot stall; results are never held back.
// Reset empties the table and the ring and sets the focus to entry 0; entry
// contents are left as they are and are never read before being written.
module scan_device_table_oldest_replace_core
  import sdt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int RING_SLOTS    = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [47:0]       device_address,
  input  logic [7:0]        address_type,
  input  logic [7:0]        adv_flag,
  input  logic signed [7:0] rssi,
  input  logic [31:0]       scan_time,
  input  logic              adv_empty,
  input  logic [5:0]        focus_req,
  output logic              done,
  output logic [2:0]        status,
  output logic [5:0]        entry_index,
  output logic              to_recent,
  output logic [4:0]        recent_slot,
  output logic [6:0]        device_count,
  output logic [5:0]        focus_index,
  output logic [4:0]        recent_count
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW = $clog2(RING_SLOTS);
  localparam int FW = $clog2(RING_SLOTS + 1);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] focus;
  logic [IW-1:0] focus_next;

  // Latched scan report.
  meta_t         meta_q;
  logic [31:0]   now_q;

  // Walk over the table.
  logic [CW-1:0] ptr;
  logic          cmp_valid;
  logic [IW-1:0] cmp_idx;
  logic [31:0]   best_time;
  logic [IW-1:0] best_idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          match;
  logic          look_done;
  logic          issue;

  // Entry memories.
  meta_t         meta_mem [TABLE_ENTRIES];
  logic [31:0]   time_mem [TABLE_ENTRIES];
  meta_t         meta_rd;
  logic [31:0]   time_rd;
  logic          meta_we;
  logic          time_we;
  logic [IW-1:0] wr_idx;

  ring_ctrl_t    ring_ctrl;
  logic [RW-1:0] ring_slot;
  logic [FW-1:0] ring_fill;

  logic          accept;
  logic          res_valid_next;
  status_t       res_status;
  status_t       res_status_next;
  logic [5:0]    res_index_next;
  logic          res_recent_next;
  logic [4:0]    res_slot_next;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign status       = res_status;
  assign device_count = 7'(count);
  assign focus_index  = 6'(focus);
  assign recent_count = 5'(ring_fill);

  assign match     = cmp_valid && (meta_rd.addr == meta_q.addr);
  assign look_done = cmp_valid && (match || (CW'(cmp_idx) == count - CW'(1)));
  assign issue     = (state == S_LOOK) && !look_done && (ptr < count);

  sdt_ring #(
    .RING_SLOTS(RING_SLOTS)
  ) u_ring (
    .clk (clk),
    .rst (rst),
    .ctrl(ring_ctrl),
    .slot(ring_slot),
    .fill(ring_fill)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_SCAN && !adv_empty) begin
          state_next = (count == '0) ? S_WRITE : S_LOOK;
        end
      end
      S_LOOK: begin
        if (look_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_next      = count;
    focus_next      = focus;
    ring_ctrl       = '0;
    meta_we         = 1'b0;
    time_we         = 1'b0;
    wr_idx          = hit_idx;
    res_valid_next  = 1'b0;
    res_status_next = ST_REJECTED;
    res_index_next  = '0;
    res_recent_next = 1'b0;
    res_slot_next   = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_SCAN: begin
              res_valid_next = adv_empty;
            end
            OP_FOCUS: begin
              res_valid_next  = 1'b1;
              // Any change of focus restarts the ring, even a refused one.
              ring_ctrl.clear = (32'(focus_req) != 32'(focus));
              if (32'(focus_req) < 32'(count)) begin
                focus_next      = IW'(focus_req);
                res_status_next = ST_FOCUS_SET;
              end else begin
                res_status_next = ST_FOCUS_REFD;
              end
            end
            OP_CLEAR: begin
              res_valid_next  = 1'b1;
              focus_next      = '0;
              count_next      = '0;
              ring_ctrl.clear = 1'b1;
              res_status_next = ST_CLEARED;
            end
            default: begin
              res_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_WRITE: begin
        res_valid_next = 1'b1;
        time_we        = 1'b1;
        if (hit) begin
          wr_idx          = hit_idx;
          res_status_next = ST_UPDATED;
          if (hit_idx == focus) begin
            ring_ctrl.claim = 1'b1;
            res_recent_next = 1'b1;
            res_slot_next   = 5'(ring_slot);
          end
        end else if (count < CW'(TABLE_ENTRIES)) begin
          meta_we         = 1'b1;
          wr_idx          = count[IW-1:0];
          count_next      = count + CW'(1);
          res_status_next = ST_ADDED;
        end else begin
          meta_we         = 1'b1;
          wr_idx          = best_idx;
          res_status_next = ST_REPLACED;
        end
        res_index_next = 6'(wr_idx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      focus <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      focus <= focus_next;
      done  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid_next) begin
      res_status  <= res_status_next;
      entry_index <= res_index_next;
      to_recent   <= res_recent_next;
      recent_slot <= res_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_q.addr <= device_address;
      meta_q.kind <= address_type;
      meta_q.flag <= adv_flag;
      meta_q.rssi <= rssi;
      now_q       <= scan_time;
      ptr         <= '0;
      hit         <= 1'b0;
    end else begin
      if (issue) begin
        ptr <= ptr + CW'(1);
      end
      if (state == S_LOOK && cmp_valid) begin
        // Strict compare keeps the lowest index on equal times.
        if (cmp_idx == '0 || time_rd < best_time) begin
          best_time <= time_rd;
          best_idx  <= cmp_idx;
        end
        if (look_done) begin
          hit     <= match;
          hit_idx <= cmp_idx;
        end
      end
    end
    cmp_idx <= ptr[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[wr_idx] <= meta_q;
    end
    meta_rd <= meta_mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[wr_idx] <= now_q;
    end
    time_rd <= time_mem[ptr[IW-1:0]];
  end

endmodule

[src/sdt_checker.sv]
module sdt_checker
  import sdt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int RING_SLOTS    = 17
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       done,
  input logic [2:0] status,
  input logic [5:0] entry_index,
  input logic       to_recent,
  input logic [4:0] recent_slot,
  input logic [6:0] device_count,
  input logic [5:0] focus_index,
  input logic [4:0] recent_count
);

  // A clear answers in the next cycle with everything emptied.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_CLEAR |=>
      done && status == ST_CLEARED && device_count == 7'd0 &&
      recent_count == 5'd0 && focus_index == 6'd0)
    else $error("clear did not empty table and ring");

  // A result beat always follows either an accepted item or a busy cycle.
  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done)
    else $error("result beat without a pending item");

  // A new entry is always appended at the end of the table.
  a_added_at_end: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_ADDED |->
      entry_index == 6'(device_count - 7'd1) && device_count != 7'd0)
    else $error("added entry not at the end of the table");

  a_count_bounds: assert property (@(posedge clk) disable iff (rst)
    done |-> device_count <= 7'(TABLE_ENTRIES) &&
      5'(recent_count) <= 5'(RING_SLOTS))
    else $error("count out of range");

  a_slot_only_on_ring: assert property (@(posedge clk) disable iff (rst)
    done && !to_recent |-> recent_slot == 5'd0)
    else $error("ring slot reported without a ring write");

endmodule

bind scan_device_table_oldest_replace_core sdt_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES),
  .RING_SLOTS   (RING_SLOTS)
) u_sdt_checker (.*);

[tb/scan_device_table_oldest_replace_core_test.sv]
`timescale 1ns / 100ps

module scan_device_table_oldest_replace_core_test;
  import sdt_pkg::*;

  localparam int TABLE = 64;
  localparam int RING = 17;
  localparam int POOL = 96;
  localparam int RANDOM_ITEMS = 1750;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [47:0]       addr;
    logic [7:0]        atype;
    logic [7:0]        aflag;
    logic signed [7:0] rssi;
    logic [31:0]       ts;
    logic              empty;
    logic [5:0]        nf;
    bit                drain;
  } device_cmd_t;

  typedef struct {
    status_t status;
    int      idx;
    int      recent;
    int      slot;
    int      count;
    int      focus;
    int      fill;
  } device_beat_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        operation;
  logic [47:0]       device_address;
  logic [7:0]        address_type;
  logic [7:0]        adv_flag;
  logic signed [7:0] rssi;
  logic [31:0]       scan_time;
  logic              adv_empty;
  logic [5:0]        focus_req;
  logic              done;
  logic [2:0]        status;
  logic [5:0]        entry_index;
  logic              to_recent;
  logic [4:0]        recent_slot;
  logic [6:0]        device_count;
  logic [5:0]        focus_index;
  logic [4:0]        recent_count;

  scan_device_table_oldest_replace_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the device table and the recent ring.
  logic [47:0] tbl_addr [TABLE];
  logic [31:0] tbl_time [TABLE];
  int n_entries;
  int cur_focus;
  int ring_head;
  int ring_tail;
  int ring_fill;

  device_cmd_t  pending_cmds[$];
  device_beat_t expected_beats[$];
  logic [47:0]  pool [POOL];
  logic [31:0]  now_s;

  bit beat_taken;
  int gap_left = 0;
  int burst_left = 1;
  int total_cmds;
  int accepted_cmds = 0;
  int beats_seen = 0;
  int errors = 0;
  int stat_by_status [8];
  int ring_claims = 0;
  int ring_peak = 0;

  function automatic device_beat_t table_step(device_cmd_t c);
    device_beat_t r;
    int hit_at;
    int oldest;
    r.status = ST_REJECTED;
    r.idx = 0;
    r.recent = 0;
    r.slot = 0;
    if (c.op == OP_SCAN && !c.empty) begin
      hit_at = -1;
      for (int i = 0; i < n_entries; i++)
        if (hit_at < 0 && tbl_addr[i] == c.addr) hit_at = i;
      if (hit_at >= 0) begin
        r.status = ST_UPDATED;
        r.idx = hit_at;
        if (hit_at == cur_focus) begin
          // The ring overwrites its oldest slot once every slot is taken.
          r.recent = 1;
          r.slot = ring_tail;
          ring_tail = (ring_tail + 1) % RING;
          if (ring_tail == ring_head) ring_head = (ring_head + 1) % RING;
          if (ring_fill < RING) ring_fill++;
        end
      end else if (n_entries < TABLE) begin
        r.status = ST_ADDED;
        r.idx = n_entries;
        n_entries++;
        tbl_addr[r.idx] = c.addr;
      end else begin
        // Strict compare, so the lowest index wins among equal times.
        oldest = 0;
        for (int i = 1; i < TABLE; i++)
          if (tbl_time[i] < tbl_time[oldest]) oldest = i;
        r.status = ST_REPLACED;
        r.idx = oldest;
        tbl_addr[oldest] = c.addr;
      end
      tbl_time[r.idx] = c.ts;
    end else if (c.op == OP_FOCUS) begin
      // Any different request empties the ring, even a refused one.
      if (int'(c.nf) != cur_focus) begin
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
      end
      if (int'(c.nf) < n_entries) begin
        cur_focus = c.nf;
        r.status = ST_FOCUS_SET;
      end else begin
        r.status = ST_FOCUS_REFD;
      end
    end else if (c.op == OP_CLEAR) begin
      cur_focus = 0;
      n_entries = 0;
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
      r.status = ST_CLEARED;
    end
    r.count = n_entries;
    r.focus = cur_focus;
    r.fill = ring_fill;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, int want);
    if (got !== want[7:0])
      report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                beats_seen, name, got, want));
  endtask

  function automatic logic [47:0] rand_addr();
    return {$urandom(), 16'($urandom())};
  endfunction

  // Mode 0 crowds times into a few values so that ties are common.
  function automatic logic [31:0] pick_time(int mode);
    case (mode)
      0: return 32'($urandom_range(0, 3));
      1: begin
        now_s += $urandom_range(0, 3);
        return now_s;
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [47:0] a, logic [7:0] ty, logic [7:0] fl,
                          logic [7:0] rs, logic [31:0] ts, logic em, logic [5:0] nf,
                          bit dr);
    device_cmd_t c;
    c.op = op;
    c.addr = a;
    c.atype = ty;
    c.aflag = fl;
    c.rssi = rs;
    c.ts = ts;
    c.empty = em;
    c.nf = nf;
    c.drain = dr;
    pending_cmds.push_back(c);
  endtask

  task automatic push_scan(logic [47:0] a, logic [31:0] ts, logic em);
    push_cmd(OP_SCAN, a, 8'($urandom()), 8'($urandom()), 8'($urandom()), ts, em,
             6'($urandom()), 1'b0);
  endtask

  task automatic push_focus(logic [5:0] nf);
    push_cmd(OP_FOCUS, rand_addr(), 8'($urandom()), 8'($urandom()), 8'($urandom()),
             $urandom(), 1'($urandom()), nf, 1'b0);
  endtask

  task automatic push_clear(bit dr);
    push_cmd(OP_CLEAR, rand_addr(), 8'($urandom()), 8'($urandom()), 8'($urandom()),
             $urandom(), 1'($urandom()), 6'($urandom()), dr);
  endtask

  // Sender: bursts of random length, random gaps, and a full drain before
  // any item marked for it.
  always @(negedge clk) begin : sender
    device_cmd_t nxt;
    if (!rst && (!start || beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain && expected_beats.size() != 0)) begin
        nxt = pending_cmds.pop_front();
        operation      <= nxt.op;
        device_address <= nxt.addr;
        address_type   <= nxt.atype;
        adv_flag       <= nxt.aflag;
        rssi           <= nxt.rssi;
        scan_time      <= nxt.ts;
        adv_empty      <= nxt.empty;
        focus_req      <= nxt.nf;
        start          <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watcher
    device_beat_t want;
    device_cmd_t  taken;
    if (!rst) begin
      if (done) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
        end else begin
          want = expected_beats.pop_front();
          check_field("status", status, int'(want.status));
          check_field("entry_index", entry_index, want.idx);
          check_field("to_recent", to_recent, want.recent);
          check_field("recent_slot", recent_slot, want.slot);
          check_field("device_count", device_count, want.count);
          check_field("focus_index", focus_index, want.focus);
          check_field("recent_count", recent_count, want.fill);
          stat_by_status[want.status]++;
          ring_claims += want.recent;
          if (want.fill > ring_peak) ring_peak = want.fill;
        end
      end
      if (start && !busy) begin
        taken.op = operation;
        taken.addr = device_address;
        taken.atype = address_type;
        taken.aflag = adv_flag;
        taken.rssi = rssi;
        taken.ts = scan_time;
        taken.empty = adv_empty;
        taken.nf = focus_req;
        taken.drain = 1'b0;
        expected_beats.push_back(table_step(taken));
        beat_taken = 1'b1;
        accepted_cmds++;
      end
    end
  end

  initial begin : main
    int scen;
    int tmode;
    int n;
    int k;
    int f;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_SCAN;
    device_address = '0;
    address_type = '0;
    adv_flag = '0;
    rssi = '0;
    scan_time = '0;
    adv_empty = 1'b0;
    focus_req = '0;
    beat_taken = 1'b0;
    n_entries = 0;
    cur_focus = 0;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    now_s = $urandom();
    // The low bits carry the index, so pool addresses never collide.
    for (int i = 0; i < POOL; i++) pool[i] = {$urandom(), 9'($urandom()), 7'(i)};

    // Directed part: extremes, every operation and the corner cases.
    push_clear(1'b0);
    push_cmd(OP_UNUSED, '1, 8'hff, 8'hff, 8'sh7f, '1, 1'b1, 6'h3f, 1'b0);
    push_focus(6'd0);
    push_scan(48'h0, 32'h0, 1'b1);
    push_cmd(OP_SCAN, 48'h0, 8'h00, 8'h00, 8'sh80, 32'h0, 1'b0, 6'h00, 1'b0);
    push_cmd(OP_SCAN, '1, 8'hff, 8'hff, 8'sh7f, '1, 1'b0, 6'h3f, 1'b0);
    push_scan(48'h0, 32'd5, 1'b0);
    push_scan(48'h0, 32'd6, 1'b0);
    push_focus(6'd1);
    push_scan('1, 32'd7, 1'b0);
    push_focus(6'd1);
    push_focus(6'd63);
    push_focus(6'd2);
    push_scan(48'h0, '1, 1'b1);
    push_cmd(OP_UNUSED, 48'h0, 8'h00, 8'h00, 8'sh80, 32'h0, 1'b0, 6'h00, 1'b0);
    push_clear(1'b0);
    push_scan(pool[0], 32'd1, 1'b0);
    push_focus(6'd0);
    push_scan(pool[0], 32'd2, 1'b0);
    push_clear(1'b1);

    n = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < n) begin
      scen = $urandom_range(0, 9);
      tmode = $urandom_range(0, 2);
      if (scen <= 2) begin
        // Fill up to or past capacity so that the oldest entries can get replaced.
        push_clear($urandom_range(0, 3) == 0);
        k = $urandom_range(60, 120);
        for (int i = 0; i < k; i++) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) push_focus(6'($urandom_range(0, 63)));
          else if (pick <= 2) push_scan(pool[$urandom_range(0, POOL - 1)], pick_time(tmode), 1'b0);
          else push_scan(rand_addr(), pick_time(tmode), $urandom_range(0, 19) == 0);
        end
      end else if (scen <= 5) begin
        // Repeated hits on the focused entry, at times long enough to wrap the ring.
        push_clear($urandom_range(0, 3) == 0);
        k = $urandom_range(1, 10);
        for (int i = 0; i < k; i++) push_scan(pool[i], pick_time(tmode), 1'b0);
        f = $urandom_range(0, k - 1);
        push_focus(6'(f));
        for (int i = $urandom_range(10, 45); i > 0; i--) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            push_focus(6'(f));
          end else if (pick == 1) begin
            pick = $urandom_range(0, k);
            push_focus(6'(pick));
            if (pick < k) f = pick;
          end else if (pick <= 3) begin
            push_scan(pool[$urandom_range(0, k - 1)], pick_time(tmode), 1'b0);
          end else begin
            push_scan(pool[f], pick_time(tmode), pick == 4);
          end
        end
      end else if (scen <= 7) begin
        // Churn over more addresses than the table holds.
        for (int i = $urandom_range(30, 80); i > 0; i--) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) push_focus(6'($urandom_range(0, 63)));
          else if (pick == 1) push_focus(6'($urandom_range(0, 15)));
          else push_scan(pool[$urandom_range(0, 79)], pick_time(tmode), pick == 2);
        end
      end else begin
        for (int i = $urandom_range(5, 20); i > 0; i--)
          push_cmd(2'($urandom_range(0, 3)),
                   ($urandom_range(0, 1) == 0) ? rand_addr() : pool[$urandom_range(0, POOL - 1)],
                   8'($urandom()), 8'($urandom()), 8'($urandom()), pick_time(2),
                   1'($urandom()), 6'($urandom()), 1'b0);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    wait (accepted_cmds == total_cmds);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Covered %0d commands: %0d added, %0d replaced oldest, %0d updated, %0d rejected.",
             beats_seen, stat_by_status[ST_ADDED], stat_by_status[ST_REPLACED],
             stat_by_status[ST_UPDATED], stat_by_status[ST_REJECTED]);
    $display("Ring took %0d packets (peak fill %0d); focus set %0d, refused %0d; %0d clears.",
             ring_claims, ring_peak, stat_by_status[ST_FOCUS_SET],
             stat_by_status[ST_FOCUS_REFD], stat_by_status[ST_CLEARED]);
    if (errors == 0) begin
      $display("** scan_device_table_oldest_replace_core: PASSED **");
    end else begin
      $display("** scan_device_table_oldest_replace_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Timed out with %0d of %0d commands taken and %0d beats outstanding.",
             accepted_cmds, total_cmds, expected_beats.size());
    $display("** scan_device_table_oldest_replace_core: FAILED **");
    $finish;
  end

endmodule
